/* hdl/nnfr_pkg.sv */
package nnfr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // Bit-serial divider: one quotient bit per cycle
  localparam logic [3:0] DIV_LAST = 4'd15;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_EVEN_OUT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ODD_OUT_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_EVEN_TIME_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ODD_TIME_STEP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TICK_PERIOD    = 3'd4;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_RESAMPLE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CALC,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic                      req_type;
    logic signed [SampleW-1:0] sample_in;
    logic                      frame_odd;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic [IndexW-1:0]         out_index;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [TimeW-1:0]   value;
  } cfg_t;

endpackage

/* hdl/nnfr_stream_if.sv */
interface nnfr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/nearest_neighbor_frame_resampler.sv */
// Nearest-neighbour frame resampler. Write transactions (req_type 0) load the frame store one
// sample per cycle, back to back, while no resample is in progress. A resample transaction
// (req_type 1) selects the even or odd count and time step, clamps the count to 1..OUT_MAX and
// then emits that many results: first it splits the time step into quotient and remainder of
// the tick period on a bit-serial divider, then for each result an address and store read and a
// presentation that holds for as long as the output is stalled.
// Frame store entries must be written before a resample reads them.
module nearest_neighbor_frame_resampler #(
  parameter int unsigned IN_LEN  = 64,
  parameter int unsigned OUT_MAX = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nnfr_stream_if.sink   cfg_i,
  nnfr_stream_if.sink   in_i,
  nnfr_stream_if.source out_o
);
  import nnfr_pkg::*;

  localparam int unsigned AW      = (IN_LEN > 1) ? $clog2(IN_LEN) : 1;
  localparam int unsigned LastIdx = IN_LEN - 1;
  localparam int unsigned SumW    = 18;
  localparam logic [AW-1:0]     LastA   = AW'(LastIdx);
  localparam logic [CountW-1:0] OutMaxC = CountW'(OUT_MAX);

  logic [SampleW-1:0] mem [IN_LEN];
  logic [SampleW-1:0] rd_q;

  fsm_e state_q, state_d;

  logic [CountW-1:0] even_cnt_q, odd_cnt_q;
  logic [TimeW-1:0]  even_step_q, odd_step_q, tick_q;

  logic [AW-1:0]     lp_q;
  logic [TimeW-1:0]  per_q;
  logic [CountW-1:0] cnt_q, m_q;
  logic [TimeW-1:0]  dq_q;     // dividend in, quotient out
  logic [TimeW-1:0]  dr_q;     // partial remainder
  logic [3:0]        div_cnt_q;
  logic [TimeW-1:0]  rem_q;
  logic [AW-1:0]     src_q;

  logic in_acc, out_acc, wr_en, rd_en, is_last;
  logic [CountW-1:0] cnt_sel, cnt_clamp;
  logic [TimeW-1:0]  step_sel;

  // divider step
  logic [TimeW:0]   r_shift, r_sub;
  logic             r_ge;
  logic [TimeW-1:0] r_next;

  // phase update
  logic [TimeW:0]   acc, acc_red;
  logic             acc_ge;
  logic [TimeW-1:0] rem_upd, half;
  logic [TimeW:0]   q;
  logic [SumW-1:0]  sum;
  logic [AW-1:0]    src_upd, sel;

  assign cfg_i.ready = 1'b1;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign is_last = (m_q + CountW'(1)) == cnt_q;

  always_comb begin
    cnt_sel  = in_i.data.frame_odd ? odd_cnt_q : even_cnt_q;
    step_sel = in_i.data.frame_odd ? odd_step_q : even_step_q;
    if (cnt_sel == '0) begin
      cnt_clamp = CountW'(1);
    end else if (cnt_sel > OutMaxC) begin
      cnt_clamp = OutMaxC;
    end else begin
      cnt_clamp = cnt_sel;
    end
  end

  always_comb begin
    r_shift = {dr_q, dq_q[TimeW-1]};
    r_sub   = r_shift - {1'b0, per_q};
    r_ge    = r_shift >= {1'b0, per_q};
    r_next  = r_ge ? r_sub[TimeW-1:0] : r_shift[TimeW-1:0];
  end

  // rem + step = rem + qs*P + rs, and rem + rs < 2P: one conditional subtract per output
  always_comb begin
    half    = per_q >> 1;
    acc     = {1'b0, rem_q} + {1'b0, dr_q};
    acc_ge  = acc >= {1'b0, per_q};
    acc_red = acc_ge ? (acc - {1'b0, per_q}) : acc;
    rem_upd = acc_red[TimeW-1:0];
    q       = {1'b0, dq_q} + {{TimeW{1'b0}}, acc_ge};
    sum     = SumW'(src_q) + SumW'(q);
    src_upd = (sum >= SumW'(LastIdx)) ? LastA : sum[AW-1:0];
    if (m_q == '0) begin
      sel = '0;
    end else if (src_upd == LastA) begin
      sel = LastA;
    end else if (rem_upd < half) begin
      sel = src_upd;
    end else begin
      sel = src_upd + AW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.data.req_type == REQ_RESAMPLE) state_d = S_DIV;
      end
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) state_d = S_CALC;
      end
      S_CALC: state_d = S_OUT;
      S_OUT: begin
        if (out_acc) state_d = is_last ? S_IDLE : S_CALC;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    rd_en       = 1'b0;
    case (state_q)
      S_IDLE:  in_i.ready  = 1'b1;
      S_CALC:  rd_en       = 1'b1;
      S_OUT:   out_o.valid = 1'b1;
      default: ;
    endcase
  end

  assign wr_en = in_acc && in_i.data.req_type == REQ_WRITE;

  assign out_o.data.out_sample = $signed(rd_q);
  assign out_o.data.out_index  = m_q[IndexW-1:0];
  assign out_o.data.last       = is_last;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[lp_q] <= in_i.data.sample_in;
    if (rd_en) rd_q <= mem[sel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_cnt_q <= CountW'(64);
      odd_cnt_q  <= CountW'(64);
      even_step_q <= TimeW'(1000);
      odd_step_q  <= TimeW'(1000);
      tick_q      <= TimeW'(1000);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        CFG_EVEN_OUT_COUNT: even_cnt_q  <= cfg_i.data.value[CountW-1:0];
        CFG_ODD_OUT_COUNT:  odd_cnt_q   <= cfg_i.data.value[CountW-1:0];
        CFG_EVEN_TIME_STEP: even_step_q <= cfg_i.data.value;
        CFG_ODD_TIME_STEP:  odd_step_q  <= cfg_i.data.value;
        CFG_TICK_PERIOD:    tick_q      <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lp_q      <= '0;
      per_q     <= TimeW'(1);
      cnt_q     <= CountW'(1);
      m_q       <= '0;
      dq_q      <= '0;
      dr_q      <= '0;
      div_cnt_q <= '0;
      rem_q     <= '0;
      src_q     <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        lp_q <= (lp_q == LastA) ? '0 : lp_q + AW'(1);
      end
      if (in_acc && in_i.data.req_type == REQ_RESAMPLE) begin
        lp_q      <= '0;
        per_q     <= (tick_q == '0) ? TimeW'(1) : tick_q;
        cnt_q     <= cnt_clamp;
        m_q       <= '0;
        dq_q      <= step_sel;
        dr_q      <= '0;
        div_cnt_q <= '0;
        rem_q     <= '0;
        src_q     <= '0;
      end
      if (state_q == S_DIV) begin
        dq_q      <= {dq_q[TimeW-2:0], r_ge};
        dr_q      <= r_next;
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      if (state_q == S_CALC && m_q != '0) begin
        rem_q <= rem_upd;
        src_q <= src_upd;
      end
      if (out_acc) m_q <= m_q + CountW'(1);
    end
  end

`ifndef SYNTHESIS
  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC || state_q == S_OUT) |-> (rem_q < per_q && dr_q < per_q))
    else $error("phase remainder not below tick period");

  a_src_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_q <= LastA)
    else $error("source index past end of frame store");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC || state_q == S_OUT) |-> m_q < cnt_q)
    else $error("output counter beyond frame length");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.data.last) |=> state_q == S_IDLE)
    else $error("frame did not end after last transaction");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input accepted while a result is pending");
`endif

endmodule
